// File: src/gcd_lcm_unit_assert.svh
// ============================================================================
// gcd_lcm_unit_assert.svh
// Assertion macros shared by the GCD/LCM unit sources.
// ============================================================================
`ifndef GCD_LCM_UNIT_ASSERT_SVH
`define GCD_LCM_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define GCDL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GCDL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/gcdl_pkg.sv
// ============================================================================
// gcdl_pkg
// Shared types, constants and helpers for the GCD/LCM unit.
// ============================================================================
package gcdl_pkg;

    localparam int DEF_OPERAND_BITS = 31;

    // shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_TWOS   = 8'b0000_0010,
        ST_ODDA   = 8'b0000_0100,
        ST_REDUCE = 8'b0000_1000,
        ST_SCALE  = 8'b0001_0000,
        ST_DIV    = 8'b0010_0000,
        ST_MUL    = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    // request from the stream front end
    typedef struct packed {
        logic start;
        logic action;   // 0 gcd, 1 lcm
    } req_t;

    // result status back to the front end
    typedef struct packed {
        logic idle;
        logic valid;
        logic invalid;
    } sts_t;

    // round a bit count up to whole bytes
    function automatic int byte_pad(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

// File: src/gcdl_alu.sv
// ============================================================================
// gcdl_alu
// Shared add/subtract unit; the top bit of the result is carry or borrow.
// ============================================================================
module gcdl_alu #(
    parameter int WIDTH = 2 * gcdl_pkg::DEF_OPERAND_BITS
) (
    input  logic [WIDTH-1:0]  x,
    input  logic [WIDTH-1:0]  y,
    input  gcdl_pkg::alu_op_t op,
    output logic [WIDTH:0]    res
);
    import gcdl_pkg::*;

    always_comb
    begin
        case (op)
            ALU_SUB: res = {1'b0, x} - {1'b0, y};
            default: res = {1'b0, x} + {1'b0, y};
        endcase
    end

endmodule

// File: src/gcdl_core.sv
// ============================================================================
// gcdl_core
// Sequencer and registers: binary GCD, then restoring divide and shift-add
// multiply for the LCM, all through one shared adder.
// ============================================================================
`include "gcd_lcm_unit_assert.svh"

module gcdl_core #(
    parameter int OPERAND_BITS = gcdl_pkg::DEF_OPERAND_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gcdl_pkg::req_t            req,
    input  logic [OPERAND_BITS-1:0]   operand_a,
    input  logic [OPERAND_BITS-1:0]   operand_b,
    input  logic                      res_ready,
    output gcdl_pkg::sts_t            sts,
    output logic [2*OPERAND_BITS-1:0] answer
);
    import gcdl_pkg::*;

    localparam int OB    = OPERAND_BITS;
    localparam int W     = 2 * OPERAND_BITS;
    localparam int CNT_W = $clog2(OPERAND_BITS);

    state_t           state_reg, state_next;
    logic             act_reg, act_next;
    logic             inv_reg, inv_next;
    logic [OB-1:0]    u_reg, u_next;
    logic [OB-1:0]    v_reg, v_next;
    logic [OB-1:0]    a_reg, a_next;
    logic [OB-1:0]    b_reg, b_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [OB-1:0]    rem_reg, rem_next;
    logic [OB-1:0]    dq_reg, dq_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     mcand_reg, mcand_next;

    logic [W-1:0]     alu_x;
    logic [W-1:0]     alu_y;
    alu_op_t          alu_op;
    logic [W:0]       alu_res;
    logic             borrow;

    gcdl_alu #(.WIDTH(W)) u_alu (
        .x   (alu_x),
        .y   (alu_y),
        .op  (alu_op),
        .res (alu_res)
    );

    assign borrow = alu_res[W];

    // operand select for the shared adder
    always_comb
    begin
        alu_x  = '0;
        alu_y  = '0;
        alu_op = ALU_ADD;
        if (state_reg == ST_REDUCE)
        begin
            alu_x  = W'(v_reg);
            alu_y  = W'(u_reg);
            alu_op = ALU_SUB;
        end
        else if (state_reg == ST_DIV)
        begin
            alu_x  = W'({rem_reg, dq_reg[OB-1]});
            alu_y  = W'(u_reg);
            alu_op = ALU_SUB;
        end
        else if (state_reg == ST_MUL)
        begin
            alu_x  = acc_reg;
            alu_y  = mcand_reg;
            alu_op = ALU_ADD;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        inv_next   = inv_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    act_next = req.action;
                    a_next   = operand_a;
                    b_next   = operand_b;
                    u_next   = operand_a;
                    v_next   = operand_b;
                    k_next   = '0;
                    if (operand_a == '0 || operand_b == '0)
                    begin
                        inv_next   = 1'b1;
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        inv_next   = 1'b0;
                        state_next = ST_TWOS;
                    end
                end
            end
            ST_TWOS:
            begin
                // strip common factors of two
                if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_ODDA;
                end
            end
            ST_ODDA:
            begin
                if (!u_reg[0])
                    u_next = u_reg >> 1;
                else
                    state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                // u stays odd; v shrinks until zero
                if (v_reg == '0)
                begin
                    state_next = ST_SCALE;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (borrow)
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
                else
                begin
                    v_next = alu_res[OB-1:0];
                end
            end
            ST_SCALE:
            begin
                if (k_reg != '0)
                begin
                    u_next = u_reg << 1;
                    k_next = k_reg - 1'b1;
                end
                else if (!act_reg)
                begin
                    acc_next   = W'(u_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    dq_next    = a_reg;
                    cnt_next   = CNT_W'(OB - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring divide a / g, one quotient bit per cycle
                if (!borrow)
                begin
                    rem_next = alu_res[OB-1:0];
                    dq_next  = {dq_reg[OB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[OB-2:0], dq_reg[OB-1]};
                    dq_next  = {dq_reg[OB-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    acc_next   = '0;
                    mcand_next = W'(b_reg);
                    cnt_next   = CNT_W'(OB - 1);
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_MUL:
            begin
                // shift-add: quotient times b
                if (dq_reg[0])
                    acc_next = alu_res[W-1:0];
                dq_next    = dq_reg >> 1;
                mcand_next = mcand_reg << 1;
                if (cnt_reg == '0)
                    state_next = ST_DONE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        inv_reg   <= inv_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign sts.idle    = (state_reg == ST_IDLE);
    assign sts.valid   = (state_reg == ST_DONE);
    assign sts.invalid = inv_reg;
    assign answer      = acc_reg;

    `GCDL_ASSERT_NXT(a_zero_short, req.start && (state_reg == ST_IDLE) && (operand_a == '0 || operand_b == '0), (state_reg == ST_DONE) && inv_reg && (acc_reg == '0), "zero operand must finish at once as invalid")
    `GCDL_ASSERT_IMP(a_u_odd, state_reg == ST_REDUCE, u_reg[0], "gcd reduce lost odd u")
    `GCDL_ASSERT_NXT(a_div_to_mul, (state_reg == ST_DIV) && (cnt_reg == '0), state_reg == ST_MUL, "divide must hand over to multiply")
    `GCDL_ASSERT_NXT(a_done_hold, (state_reg == ST_DONE) && !res_ready, (state_reg == ST_DONE) && $stable(acc_reg), "result lost before taken")

endmodule

// File: src/gcd_lcm_unit.sv
// ============================================================================
// gcd_lcm_unit
// Returns gcd(a, b) or lcm(a, b) of two unsigned operands; either operand
// zero gives answer 0 with the invalid flag set.
// ============================================================================
// One word is worked at a time; s_axis_tready is low while it is in flight.
// An item with a zero operand goes straight to the done state. Otherwise the
// binary GCD strips common factors of two, halves a down to odd, reduces by
// shifts and subtractions until v is zero, then scales the result back. LCM
// then runs a restoring divide a / gcd and a shift-add multiply by b.
// Subtractions and additions share one 2*OPERAND_BITS-bit adder, so they
// run one after another. A finished result sits in the output register,
// so the next word is taken while it waits for m_axis_tready.
// ============================================================================
`include "gcd_lcm_unit_assert.svh"

module gcd_lcm_unit #(
    parameter int OPERAND_BITS = gcdl_pkg::DEF_OPERAND_BITS
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // operand_a, operand_b, zero pad
    input  logic [gcdl_pkg::byte_pad(2*OPERAND_BITS)-1:0] s_axis_tdata,
    // action: 0 gcd, 1 lcm
    input  logic s_axis_tuser,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // answer, zero pad
    output logic [gcdl_pkg::byte_pad(2*OPERAND_BITS)-1:0] m_axis_tdata,
    // invalid
    output logic m_axis_tuser
);
    import gcdl_pkg::*;

    localparam int OB    = OPERAND_BITS;
    localparam int W     = 2 * OPERAND_BITS;
    localparam int OUT_W = byte_pad(2 * OPERAND_BITS);

    req_t         req;
    sts_t         sts;
    logic [W-1:0] core_answer;
    logic         load;

    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_ans_reg, out_ans_next;
    logic         out_inv_reg, out_inv_next;

    assign s_axis_tready = sts.idle;
    assign req.start     = s_axis_tvalid && sts.idle;
    assign req.action    = s_axis_tuser;

    gcdl_core #(.OPERAND_BITS(OB)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .operand_a (s_axis_tdata[OB-1:0]),
        .operand_b (s_axis_tdata[2*OB-1:OB]),
        .res_ready (load),
        .sts       (sts),
        .answer    (core_answer)
    );

    // output register frees the core as soon as the word is parked
    assign load = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ans_next   = out_ans_reg;
        out_inv_next   = out_inv_reg;
        if (load)
        begin
            out_valid_next = sts.valid;
            if (sts.valid)
            begin
                out_ans_next = core_answer;
                out_inv_next = sts.invalid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_ans_reg <= out_ans_next;
        out_inv_reg <= out_inv_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_ans_reg);
    assign m_axis_tuser  = out_inv_reg;

    `GCDL_ASSERT_NXT(a_park, sts.valid && load, m_axis_tvalid && (m_axis_tuser == $past(sts.invalid)), "finished result not parked")
    `GCDL_ASSERT_IMP(a_inv_zero, m_axis_tvalid && m_axis_tuser, out_ans_reg == '0, "invalid word with nonzero answer")
    `GCDL_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while busy")

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for gcd_lcm_unit. Words of action and two operands go
// in over the slave stream; each answer word is checked against a GCD/LCM
// computed in the bench. Directed corner words come first, then random words
// under no idling, a slow sender, a stalling receiver, and both at once.
// ============================================================================
module testbench;

    localparam int OPERAND_BITS = gcdl_pkg::DEF_OPERAND_BITS;
    localparam int WORD_BITS    = gcdl_pkg::byte_pad(2*OPERAND_BITS);
    localparam int ANSWER_BITS  = 2*OPERAND_BITS;
    localparam int PAD_BITS     = WORD_BITS - 2*OPERAND_BITS;

    localparam logic ACT_GCD = 1'b0;
    localparam logic ACT_LCM = 1'b1;

    localparam logic [OPERAND_BITS-1:0] OP_MAX = {OPERAND_BITS{1'b1}};

    localparam int RANDOM_WORDS  = 257;
    localparam int DRAIN_CYCLES  = 300;
    localparam int REPORT_LIMIT  = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [WORD_BITS-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [WORD_BITS-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int fail_count     = 0;

    logic [ANSWER_BITS-1:0] pending_answer_q[$];
    logic                   pending_invalid_q[$];

    gcd_lcm_unit #(
        .OPERAND_BITS (OPERAND_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

    // Euclid on 64-bit values; lcm = (a / gcd) * b always fits 2*OPERAND_BITS
    function automatic void calc_gcd_lcm(input logic act,
                                         input logic [OPERAND_BITS-1:0] a,
                                         input logic [OPERAND_BITS-1:0] b,
                                         output logic [ANSWER_BITS-1:0] answer,
                                         output logic invalid);
        longint unsigned x;
        longint unsigned y;
        longint unsigned r;
        x = 64'(a);
        y = 64'(b);
        answer  = '0;
        invalid = 1'b0;
        if (a == '0 || b == '0)
        begin
            invalid = 1'b1;
        end
        else
        begin
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            if (act == ACT_GCD)
                answer = x[ANSWER_BITS-1:0];
            else
                answer = ANSWER_BITS'((longint'(a) / x) * longint'(b));
        end
    endfunction

    function automatic logic [OPERAND_BITS-1:0] rand_bits(input int width);
        logic [31:0] r;
        r = $urandom();
        return r[OPERAND_BITS-1:0] & (OP_MAX >> (OPERAND_BITS - width));
    endfunction

    task automatic send_word(input logic act,
                             input logic [OPERAND_BITS-1:0] a,
                             input logic [OPERAND_BITS-1:0] b);
        logic [ANSWER_BITS-1:0] answer;
        logic                   invalid;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_BITS{1'b0}}, b, a};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        calc_gcd_lcm(act, a, b, answer, invalid);
        pending_answer_q.push_back(answer);
        pending_invalid_q.push_back(invalid);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_answer_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver side: random stalls and the result check
    always @(posedge clk)
    begin
        logic [ANSWER_BITS-1:0] exp_answer;
        logic                   exp_invalid;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_answer_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected word answer=%0d invalid=%0b",
                                 $realtime, m_axis_tdata[ANSWER_BITS-1:0], m_axis_tuser);
                end
                else
                begin
                    exp_answer  = pending_answer_q.pop_front();
                    exp_invalid = pending_invalid_q.pop_front();
                    if (m_axis_tdata[ANSWER_BITS-1:0] !== exp_answer
                        || m_axis_tuser !== exp_invalid)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: mismatch answer exp %0d got %0d, invalid exp %0b got %0b",
                                     $realtime, exp_answer, m_axis_tdata[ANSWER_BITS-1:0],
                                     exp_invalid, m_axis_tuser);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // zero operands, both actions
        send_word(ACT_GCD, 0, 0);
        send_word(ACT_LCM, 0, 0);
        send_word(ACT_GCD, 0, 5);
        send_word(ACT_LCM, 7, 0);
        send_word(ACT_GCD, OP_MAX, 0);
        send_word(ACT_LCM, 0, OP_MAX);
        // unit and full-scale operands
        send_word(ACT_GCD, 1, 1);
        send_word(ACT_LCM, 1, 1);
        send_word(ACT_GCD, 1, OP_MAX);
        send_word(ACT_LCM, OP_MAX, 1);
        send_word(ACT_GCD, OP_MAX, OP_MAX);
        send_word(ACT_LCM, OP_MAX, OP_MAX);
        // coprime neighbors: largest possible lcm
        send_word(ACT_GCD, OP_MAX, OP_MAX - 1'b1);
        send_word(ACT_LCM, OP_MAX, OP_MAX - 1'b1);
        // one operand divides the other, then coprime and shared-factor pairs
        send_word(ACT_GCD, 21, 7);
        send_word(ACT_LCM, 7, 21);
        send_word(ACT_GCD, 31'h4000_0000, 31'h2000_0000);
        send_word(ACT_LCM, 31'h4000_0000, 3);
        send_word(ACT_GCD, 12, 18);
        send_word(ACT_LCM, 12, 18);
        // alternating bit patterns
        send_word(ACT_GCD, 31'h5555_5555, 31'h2AAA_AAAA);
        send_word(ACT_LCM, 31'h2AAA_AAAA, 31'h5555_5555);
        wait_drained();
    endtask

    task automatic run_random(input int count);
        logic                    act;
        logic [OPERAND_BITS-1:0] a;
        logic [OPERAND_BITS-1:0] b;
        logic [OPERAND_BITS-1:0] g;
        logic [OPERAND_BITS-1:0] tmp;
        int                      pick;
        int                      gw;
        for (int i = 0; i < count; i++)
        begin
            act  = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                a = rand_bits(OPERAND_BITS);
                b = rand_bits(OPERAND_BITS);
            end
            else if (pick < 65)
            begin
                a = rand_bits($urandom_range(1, OPERAND_BITS));
                b = rand_bits($urandom_range(1, OPERAND_BITS));
            end
            else if (pick < 90)
            begin
                // shared factor so the gcd is large
                gw = $urandom_range(1, 16);
                g  = rand_bits(gw);
                if (g == '0)
                    g = 1;
                a = g * rand_bits($urandom_range(1, OPERAND_BITS - gw));
                b = g * rand_bits($urandom_range(1, OPERAND_BITS - gw));
            end
            else if (pick < 95)
            begin
                a = rand_bits($urandom_range(1, OPERAND_BITS - 3));
                b = OPERAND_BITS'(a * $urandom_range(1, 7));
            end
            else
            begin
                a = ($urandom_range(0, 1) == 0) ? '0 : rand_bits(OPERAND_BITS);
                b = '0;
            end
            if ($urandom_range(0, 1) == 1)
            begin
                tmp = a;
                a   = b;
                b   = tmp;
            end
            send_word(act, a, b);
        end
        wait_drained();
    endtask

    task automatic test_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random(RANDOM_WORDS);
    endtask

    task automatic test_sender_idle();
        src_idle_pct   = 52;
        sink_stall_pct = 0;
        run_random(RANDOM_WORDS);
    endtask

    task automatic test_receiver_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 52;
        run_random(RANDOM_WORDS);
    endtask

    task automatic test_both_idle();
        src_idle_pct   = 35;
        sink_stall_pct = 35;
        run_random(RANDOM_WORDS);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        sink_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_answer_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
